// ----- rtl/mmt_pkg.sv -----
package mmt_pkg;

	localparam int TOKEN_MAX_DEF = 31;
	localparam int POS_BITS_DEF  = 16;
	localparam int OUT_POS_W     = 16;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [1:0] KIND_END  = 2'd0;
	localparam logic [1:0] KIND_SYM  = 2'd1;
	localparam logic [1:0] KIND_WORD = 2'd2;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_NUMBER, M_NUMDOT, M_FRACTION,
		M_BACKSLASH, M_CTRLWORD, M_NAME, M_UTF8
	} mode_t;

	typedef enum logic [2:0] {
		CS_WAIT, CS_STEP, CS_APPC, CS_DOT, CS_FRESH, CS_EMIT, CS_END
	} ctl_state_t;

	typedef enum logic [1:0] {
		APP_NONE, APP_C, APP_DOT
	} app_src_t;

	typedef struct packed {
		logic       load_c;
		app_src_t   app;
		logic       start;      // begin a new token with this append
		logic [1:0] kind;
		logic       adv_c;      // move counters over c without storing it
		logic       mark_pos;   // token start := current position
		logic       set_rem;
		logic       dec_rem;
		logic       take;       // one buffered byte leaves
		logic       out_end;
	} dp_cmd_t;

	typedef struct packed {
		logic       is_zero;
		logic       is_digit;
		logic       is_alpha;
		logic       is_dot;
		logic       is_blank;
		logic       is_lf;
		logic       is_pct;
		logic       is_sym;
		logic       is_bslash;
		logic       is_cont;
		logic [1:0] utf_extra;
		logic       full_next;
		logic       last_byte;
		logic       rem_le1;
	} dp_stat_t;

	function automatic logic is_sym_ch(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h7B, 8'h7D, 8'h5E, 8'h5F, 8'h28, 8'h29, 8'h2B, 8'h2D,
			8'h3D, 8'h2A, 8'h2F, 8'h5B, 8'h5D, 8'h7C, CH_DOLLAR: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/mmt_if.sv -----
interface mmt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface mmt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  text_byte;
	logic [15:0] start_line;
	logic [15:0] start_col;
	logic [15:0] tail_line;
	logic [15:0] end_col;
	logic        last;
	modport source (output valid, output kind, output text_byte, output start_line,
		output start_col, output tail_line, output end_col, output last, input ready);
	modport sink (input valid, input kind, input text_byte, input start_line,
		input start_col, input tail_line, input end_col, input last, output ready);
endinterface

// ----- rtl/mmt_dp.sv -----
module mmt_dp #(
	parameter int TOKEN_MAX = mmt_pkg::TOKEN_MAX_DEF,
	parameter int POS_BITS  = mmt_pkg::POS_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         in_ch,
	input  mmt_pkg::dp_cmd_t   cmd,
	output mmt_pkg::dp_stat_t  stat,
	output logic [1:0]         kind,
	output logic [7:0]         text_byte,
	output logic [mmt_pkg::OUT_POS_W-1:0] start_line,
	output logic [mmt_pkg::OUT_POS_W-1:0] start_col,
	output logic [mmt_pkg::OUT_POS_W-1:0] tail_line,
	output logic [mmt_pkg::OUT_POS_W-1:0] end_col,
	output logic               last
);
	localparam int LEN_W = $clog2(TOKEN_MAX + 1);
	localparam int IDX_W = $clog2(TOKEN_MAX);
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

	logic [7:0]          c_q;
	logic [7:0]          buf_q [TOKEN_MAX];
	logic [LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]    idx_q;
	logic [1:0]          kind_q;
	logic [1:0]          rem_q;
	logic [POS_BITS-1:0] line_q, col_q, sline_q, scol_q;

	logic [7:0]          app_byte;
	logic                do_adv;
	logic [7:0]          adv_byte;
	logic [LEN_W-1:0]    wr_len;

	always_comb begin
		stat.is_zero   = (c_q == mmt_pkg::CH_NUL);
		stat.is_digit  = (c_q >= 8'h30) && (c_q <= 8'h39);
		stat.is_alpha  = ((c_q >= 8'h61) && (c_q <= 8'h7A)) || ((c_q >= 8'h41) && (c_q <= 8'h5A));
		stat.is_dot    = (c_q == mmt_pkg::CH_DOT);
		stat.is_lf     = (c_q == mmt_pkg::CH_LF);
		stat.is_blank  = (c_q == mmt_pkg::CH_SPACE) || (c_q == mmt_pkg::CH_TAB) ||
			(c_q == mmt_pkg::CH_CR) || (c_q == mmt_pkg::CH_LF);
		stat.is_pct    = (c_q == mmt_pkg::CH_PCT);
		stat.is_sym    = mmt_pkg::is_sym_ch(c_q);
		stat.is_bslash = (c_q == mmt_pkg::CH_BSLASH);
		stat.is_cont   = (c_q[7:6] == 2'b10);
		if (c_q[7:5] == 3'b110)
			stat.utf_extra = 2'd1;
		else if (c_q[7:4] == 4'b1110)
			stat.utf_extra = 2'd2;
		else if (c_q[7:3] == 5'b11110)
			stat.utf_extra = 2'd3;
		else
			stat.utf_extra = 2'd0;
		stat.full_next = (len_q + LEN_W'(1)) == LEN_W'(TOKEN_MAX);
		stat.last_byte = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;
		stat.rem_le1   = (rem_q <= 2'd1);
	end

	assign app_byte = (cmd.app == mmt_pkg::APP_DOT) ? mmt_pkg::CH_DOT : c_q;
	assign do_adv   = cmd.adv_c || (cmd.app != mmt_pkg::APP_NONE);
	assign adv_byte = cmd.adv_c ? c_q : app_byte;
	assign wr_len   = cmd.start ? '0 : len_q;

	always_ff @(posedge clk) begin
		if (cmd.load_c)
			c_q <= in_ch;
		if (cmd.app != mmt_pkg::APP_NONE)
			buf_q[wr_len[IDX_W-1:0]] <= app_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			idx_q   <= '0;
			kind_q  <= mmt_pkg::KIND_END;
			rem_q   <= '0;
			line_q  <= POS_ONE;
			col_q   <= POS_ONE;
			sline_q <= POS_ONE;
			scol_q  <= POS_ONE;
		end else begin
			if (cmd.start || cmd.mark_pos) begin
				sline_q <= line_q;
				scol_q  <= col_q;
			end
			if (cmd.start)
				kind_q <= cmd.kind;
			if (cmd.app != mmt_pkg::APP_NONE)
				len_q <= wr_len + LEN_W'(1);
			if (cmd.set_rem)
				rem_q <= stat.utf_extra;
			else if (cmd.dec_rem && rem_q != 2'd0)
				rem_q <= rem_q - 2'd1;
			if (do_adv) begin
				if (adv_byte == mmt_pkg::CH_LF) begin
					if (line_q != POS_MAX)
						line_q <= line_q + POS_ONE;
					col_q <= POS_ONE;
				end else if (col_q != POS_MAX) begin
					col_q <= col_q + POS_ONE;
				end
			end
			if (cmd.take) begin
				if (stat.last_byte) begin
					idx_q <= '0;
					len_q <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	assign kind       = cmd.out_end ? mmt_pkg::KIND_END : kind_q;
	assign text_byte  = cmd.out_end ? mmt_pkg::CH_NUL : buf_q[idx_q];
	assign last       = cmd.out_end ? 1'b1 : stat.last_byte;
	assign start_line = mmt_pkg::OUT_POS_W'(sline_q);
	assign start_col  = mmt_pkg::OUT_POS_W'(scol_q);
	assign tail_line  = mmt_pkg::OUT_POS_W'(line_q);
	assign end_col    = mmt_pkg::OUT_POS_W'(col_q);

endmodule

// ----- rtl/mmt_ctrl.sv -----
module mmt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mmt_pkg::dp_stat_t stat,
	output mmt_pkg::dp_cmd_t  cmd
);
	mmt_pkg::ctl_state_t state_q, state_d, ret_q, ret_d;
	mmt_pkg::mode_t      mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmt_pkg::CS_WAIT;
			ret_q   <= mmt_pkg::CS_WAIT;
			mode_q  <= mmt_pkg::M_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		mode_d    = mode_q;
		cmd       = '0;
		cmd.app   = mmt_pkg::APP_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			mmt_pkg::CS_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_c = 1'b1;
					state_d    = mmt_pkg::CS_STEP;
				end
			end
			mmt_pkg::CS_STEP: begin
				state_d = mmt_pkg::CS_WAIT;
				unique case (mode_q)
					mmt_pkg::M_COMMENT: begin
						if (stat.is_zero) begin
							state_d = mmt_pkg::CS_FRESH;
						end else begin
							cmd.adv_c = 1'b1;
							if (stat.is_lf)
								mode_d = mmt_pkg::M_IDLE;
						end
					end
					mmt_pkg::M_NUMBER, mmt_pkg::M_FRACTION, mmt_pkg::M_CTRLWORD,
					mmt_pkg::M_NAME: begin
						if ((mode_q == mmt_pkg::M_NUMBER && stat.is_digit) ||
							(mode_q == mmt_pkg::M_FRACTION && stat.is_digit) ||
							(mode_q == mmt_pkg::M_CTRLWORD && stat.is_alpha) ||
							(mode_q == mmt_pkg::M_NAME && (stat.is_alpha || stat.is_digit))) begin
							cmd.app = mmt_pkg::APP_C;
							if (stat.full_next) begin
								state_d = mmt_pkg::CS_EMIT;
								ret_d   = mmt_pkg::CS_WAIT;
								mode_d  = mmt_pkg::M_IDLE;
							end
						end else if (mode_q == mmt_pkg::M_NUMBER && stat.is_dot) begin
							mode_d = mmt_pkg::M_NUMDOT;
						end else begin
							state_d = mmt_pkg::CS_EMIT;
							ret_d   = mmt_pkg::CS_FRESH;
							mode_d  = mmt_pkg::M_IDLE;
						end
					end
					mmt_pkg::M_NUMDOT: begin
						if (stat.is_digit) begin
							cmd.app = mmt_pkg::APP_DOT;
							if (stat.full_next) begin
								state_d = mmt_pkg::CS_EMIT;
								ret_d   = mmt_pkg::CS_FRESH;
								mode_d  = mmt_pkg::M_IDLE;
							end else begin
								state_d = mmt_pkg::CS_APPC;
								mode_d  = mmt_pkg::M_FRACTION;
							end
						end else begin
							// number goes out, then the held dot as a symbol
							state_d = mmt_pkg::CS_EMIT;
							ret_d   = mmt_pkg::CS_DOT;
							mode_d  = mmt_pkg::M_IDLE;
						end
					end
					mmt_pkg::M_BACKSLASH: begin
						if (stat.is_zero) begin
							state_d = mmt_pkg::CS_EMIT;
							ret_d   = mmt_pkg::CS_FRESH;
							mode_d  = mmt_pkg::M_IDLE;
						end else if (stat.is_alpha) begin
							cmd.app = mmt_pkg::APP_C;
							mode_d  = mmt_pkg::M_CTRLWORD;
							if (stat.full_next) begin
								state_d = mmt_pkg::CS_EMIT;
								ret_d   = mmt_pkg::CS_WAIT;
								mode_d  = mmt_pkg::M_IDLE;
							end
						end else begin
							cmd.app = mmt_pkg::APP_C;
							state_d = mmt_pkg::CS_EMIT;
							ret_d   = mmt_pkg::CS_WAIT;
							mode_d  = mmt_pkg::M_IDLE;
						end
					end
					mmt_pkg::M_UTF8: begin
						if (stat.is_cont) begin
							cmd.app     = mmt_pkg::APP_C;
							cmd.dec_rem = 1'b1;
							if (stat.full_next || stat.rem_le1) begin
								state_d = mmt_pkg::CS_EMIT;
								ret_d   = mmt_pkg::CS_WAIT;
								mode_d  = mmt_pkg::M_IDLE;
							end
						end else begin
							state_d = mmt_pkg::CS_EMIT;
							ret_d   = mmt_pkg::CS_FRESH;
							mode_d  = mmt_pkg::M_IDLE;
						end
					end
					default: begin
						mode_d  = mmt_pkg::M_IDLE;
						state_d = mmt_pkg::CS_FRESH;
					end
				endcase
			end
			mmt_pkg::CS_APPC: begin
				cmd.app = mmt_pkg::APP_C;
				state_d = mmt_pkg::CS_WAIT;
				if (stat.full_next) begin
					state_d = mmt_pkg::CS_EMIT;
					ret_d   = mmt_pkg::CS_WAIT;
					mode_d  = mmt_pkg::M_IDLE;
				end
			end
			mmt_pkg::CS_DOT: begin
				cmd.start = 1'b1;
				cmd.kind  = mmt_pkg::KIND_SYM;
				cmd.app   = mmt_pkg::APP_DOT;
				state_d   = mmt_pkg::CS_EMIT;
				ret_d     = mmt_pkg::CS_FRESH;
			end
			mmt_pkg::CS_FRESH: begin
				state_d = mmt_pkg::CS_WAIT;
				mode_d  = mmt_pkg::M_IDLE;
				if (stat.is_zero) begin
					cmd.mark_pos = 1'b1;
					state_d      = mmt_pkg::CS_END;
				end else if (stat.is_blank) begin
					cmd.adv_c = 1'b1;
				end else if (stat.is_pct) begin
					cmd.adv_c = 1'b1;
					mode_d    = mmt_pkg::M_COMMENT;
				end else begin
					// a fresh token never fills the buffer on its first byte
					cmd.start = 1'b1;
					cmd.app   = mmt_pkg::APP_C;
					cmd.kind  = mmt_pkg::KIND_WORD;
					if (stat.is_sym) begin
						cmd.kind = mmt_pkg::KIND_SYM;
						state_d  = mmt_pkg::CS_EMIT;
						ret_d    = mmt_pkg::CS_WAIT;
					end else if (stat.is_digit) begin
						mode_d = mmt_pkg::M_NUMBER;
					end else if (stat.is_bslash) begin
						mode_d = mmt_pkg::M_BACKSLASH;
					end else if (stat.is_alpha) begin
						mode_d = mmt_pkg::M_NAME;
					end else begin
						cmd.kind = mmt_pkg::KIND_SYM;
						if (stat.utf_extra == 2'd0) begin
							state_d = mmt_pkg::CS_EMIT;
							ret_d   = mmt_pkg::CS_WAIT;
						end else begin
							cmd.set_rem = 1'b1;
							mode_d      = mmt_pkg::M_UTF8;
						end
					end
				end
			end
			mmt_pkg::CS_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.take = 1'b1;
					if (stat.last_byte)
						state_d = ret_q;
				end
			end
			mmt_pkg::CS_END: begin
				out_valid   = 1'b1;
				cmd.out_end = 1'b1;
				if (out_ready)
					state_d = mmt_pkg::CS_WAIT;
			end
			default: state_d = mmt_pkg::CS_WAIT;
		endcase
	end

endmodule

// ----- rtl/math_markup_tokenizer.sv -----
// Byte tokenizer: one text byte per item, tokens leave one byte per result.
// Each byte is accepted (CS_WAIT), then classified (CS_STEP); a byte that
// ends a token without joining it waits while the buffer is emitted
// (CS_EMIT), then starts the next token (CS_FRESH). One item in flight at a time.
// Reset: asynchronous, active low; scanner idle, line and column at one.
module math_markup_tokenizer #(
	parameter int TOKEN_MAX = mmt_pkg::TOKEN_MAX_DEF,
	parameter int POS_BITS  = mmt_pkg::POS_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mmt_in_if.sink    text_in,
	mmt_out_if.source tok_out
);
	mmt_pkg::dp_cmd_t  cmd;
	mmt_pkg::dp_stat_t stat;

	mmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text_in.valid),
		.in_ready  (text_in.ready),
		.out_valid (tok_out.valid),
		.out_ready (tok_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mmt_dp #(
		.TOKEN_MAX (TOKEN_MAX),
		.POS_BITS  (POS_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (text_in.ch),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (tok_out.kind),
		.text_byte  (tok_out.text_byte),
		.start_line (tok_out.start_line),
		.start_col  (tok_out.start_col),
		.tail_line  (tok_out.tail_line),
		.end_col    (tok_out.end_col),
		.last       (tok_out.last)
	);

endmodule

// ----- tb/tb_math_markup_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_math_markup_tokenizer;

	localparam int TMAX = mmt_pkg::TOKEN_MAX_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  text_byte;
		logic [15:0] start_line;
		logic [15:0] start_col;
		logic [15:0] tail_line;
		logic [15:0] end_col;
		logic        last;
	} tok_byte_t;

	logic clk;
	logic arst_n;

	mmt_in_if  text_in ();
	mmt_out_if tok_out ();

	math_markup_tokenizer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in.sink),
		.tok_out(tok_out.source)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// scanner shadow state
	mmt_pkg::mode_t sc_mode;
	logic [7:0]  sc_buf [TMAX];
	int          sc_len;
	logic [1:0]  sc_kind;
	int          sc_rem;
	logic [15:0] sc_line, sc_col, sc_tline, sc_tcol;

	tok_byte_t   expected_bytes[$];
	logic [7:0]  pending_text[$];

	int  n_errors;
	int  idle_cycles;
	bit  hold_sink;
	bit  pause_src;
	bit  stim_done;

	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_let(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_symbol(logic [7:0] c);
		case (c)
			"{", "}", "^", "_", "(", ")", "+", "-", "=", "*", "/", "[", "]", "|",
			mmt_pkg::CH_DOLLAR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic move_pos(logic [7:0] c);
		if (c == mmt_pkg::CH_LF) begin
			if (sc_line != 16'hFFFF) sc_line++;
			sc_col = 1;
		end else if (sc_col != 16'hFFFF) begin
			sc_col++;
		end
	endtask

	task automatic push_byte(logic [1:0] k, logic [7:0] b, logic l);
		tok_byte_t t;
		t.kind = k;
		t.text_byte = b;
		t.start_line = sc_tline;
		t.start_col = sc_tcol;
		t.tail_line = sc_line;
		t.end_col = sc_col;
		t.last = l;
		expected_bytes.push_back(t);
	endtask

	task automatic flush_token();
		for (int i = 0; i < sc_len; i++)
			push_byte(sc_kind, sc_buf[i], i + 1 == sc_len);
		sc_len = 0;
		sc_mode = mmt_pkg::M_IDLE;
	endtask

	task automatic open_token(logic [1:0] k, mmt_pkg::mode_t m);
		sc_tline = sc_line;
		sc_tcol = sc_col;
		sc_kind = k;
		sc_len = 0;
		sc_mode = m;
	endtask

	task automatic add_byte(logic [7:0] c);
		if (sc_len < TMAX) begin
			sc_buf[sc_len] = c;
			sc_len++;
		end
		move_pos(c);
		if (sc_len >= TMAX) flush_token();
	endtask

	task automatic single_token(logic [1:0] k, logic [7:0] c);
		open_token(k, mmt_pkg::M_IDLE);
		add_byte(c);
		if (sc_len != 0) flush_token();
	endtask

	task automatic scan_idle(logic [7:0] c);
		int extra;
		if (c == mmt_pkg::CH_NUL) begin
			sc_tline = sc_line;
			sc_tcol = sc_col;
			push_byte(mmt_pkg::KIND_END, 8'h00, 1'b1);
			sc_mode = mmt_pkg::M_IDLE;
		end else if (c == mmt_pkg::CH_SPACE || c == mmt_pkg::CH_TAB || c == mmt_pkg::CH_CR
				|| c == mmt_pkg::CH_LF) begin
			move_pos(c);
		end else if (c == mmt_pkg::CH_PCT) begin
			move_pos(c);
			sc_mode = mmt_pkg::M_COMMENT;
		end else if (is_symbol(c)) begin
			single_token(mmt_pkg::KIND_SYM, c);
		end else if (is_dig(c)) begin
			open_token(mmt_pkg::KIND_WORD, mmt_pkg::M_NUMBER);
			add_byte(c);
		end else if (c == mmt_pkg::CH_BSLASH) begin
			open_token(mmt_pkg::KIND_WORD, mmt_pkg::M_BACKSLASH);
			add_byte(c);
		end else if (is_let(c)) begin
			open_token(mmt_pkg::KIND_WORD, mmt_pkg::M_NAME);
			add_byte(c);
		end else begin
			extra = 0;
			if (c >= 8'hC0 && c < 8'hE0) extra = 1;
			else if (c >= 8'hE0 && c < 8'hF0) extra = 2;
			else if (c >= 8'hF0 && c < 8'hF8) extra = 3;
			if (extra == 0) begin
				single_token(mmt_pkg::KIND_SYM, c);
			end else begin
				open_token(mmt_pkg::KIND_SYM, mmt_pkg::M_UTF8);
				sc_rem = extra;
				add_byte(c);
			end
		end
	endtask

	task automatic predict_tokens(logic [7:0] c);
		bit fresh;
		fresh = 1'b0;
		case (sc_mode)
			mmt_pkg::M_COMMENT: begin
				if (c == mmt_pkg::CH_NUL) fresh = 1'b1;
				else begin
					move_pos(c);
					if (c == mmt_pkg::CH_LF) sc_mode = mmt_pkg::M_IDLE;
				end
			end
			mmt_pkg::M_NUMBER: begin
				if (is_dig(c)) add_byte(c);
				else if (c == mmt_pkg::CH_DOT) sc_mode = mmt_pkg::M_NUMDOT;
				else begin
					flush_token();
					fresh = 1'b1;
				end
			end
			mmt_pkg::M_NUMDOT: begin
				if (is_dig(c)) begin
					sc_mode = mmt_pkg::M_FRACTION;
					add_byte(mmt_pkg::CH_DOT);
					if (sc_mode == mmt_pkg::M_IDLE) fresh = 1'b1;
					else add_byte(c);
				end else begin
					flush_token();
					single_token(mmt_pkg::KIND_SYM, mmt_pkg::CH_DOT);
					fresh = 1'b1;
				end
			end
			mmt_pkg::M_FRACTION, mmt_pkg::M_CTRLWORD: begin
				if ((sc_mode == mmt_pkg::M_FRACTION) ? is_dig(c) : is_let(c)) add_byte(c);
				else begin
					flush_token();
					fresh = 1'b1;
				end
			end
			mmt_pkg::M_NAME: begin
				if (is_dig(c) || is_let(c)) add_byte(c);
				else begin
					flush_token();
					fresh = 1'b1;
				end
			end
			mmt_pkg::M_BACKSLASH: begin
				if (c == mmt_pkg::CH_NUL) begin
					flush_token();
					fresh = 1'b1;
				end else if (is_let(c)) begin
					sc_mode = mmt_pkg::M_CTRLWORD;
					add_byte(c);
				end else begin
					add_byte(c);
					if (sc_len != 0) flush_token();
				end
			end
			mmt_pkg::M_UTF8: begin
				if (c[7:6] == 2'b10) begin
					add_byte(c);
					if (sc_rem > 0) sc_rem--;
					if (sc_mode == mmt_pkg::M_UTF8 && sc_rem == 0) flush_token();
				end else begin
					flush_token();
					fresh = 1'b1;
				end
			end
			default: begin
				sc_mode = mmt_pkg::M_IDLE;
				fresh = 1'b1;
			end
		endcase
		if (fresh) scan_idle(c);
	endtask

	// random token generators
	function automatic logic [7:0] rnd_letter();
		return $urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25))
			: 8'(8'h41 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rnd_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	task automatic add_text(logic [7:0] c);
		pending_text.push_back(c);
	endtask

	task automatic add_str(string s);
		foreach (s[i]) pending_text.push_back(s[i]);
	endtask

	task automatic gen_fragment();
		int n;
		logic [7:0] syms [15] = '{"{", "}", "^", "_", "(", ")", "+", "-", "=", "*", "/",
			"[", "]", "|", "$"};
		case ($urandom_range(0, 13))
			0, 1: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 6);
				add_text(rnd_letter());
				for (int i = 1; i < n; i++)
					add_text($urandom_range(0, 2) ? rnd_letter() : rnd_digit());
			end
			2, 3: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 4);
				for (int i = 0; i < n; i++) add_text(rnd_digit());
				if ($urandom_range(0, 1)) begin
					add_text(mmt_pkg::CH_DOT);
					if ($urandom_range(0, 3)) begin
						n = $urandom_range(1, 4);
						for (int i = 0; i < n; i++) add_text(rnd_digit());
					end
				end
			end
			4: begin
				add_text(mmt_pkg::CH_BSLASH);
				n = $urandom_range(0, 5);
				if (n == 0) add_text(8'($urandom_range(1, 255)));
				else for (int i = 0; i < n; i++) add_text(rnd_letter());
			end
			5, 6: add_text(syms[$urandom_range(0, 14)]);
			7: begin
				n = $urandom_range(1, 3);
				case (n)
					1: add_text(8'($urandom_range(8'hC0, 8'hDF)));
					2: add_text(8'($urandom_range(8'hE0, 8'hEF)));
					default: add_text(8'($urandom_range(8'hF0, 8'hF7)));
				endcase
				if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n + 1);
				for (int i = 0; i < n; i++) add_text(8'($urandom_range(8'h80, 8'hBF)));
			end
			8: begin
				add_text(mmt_pkg::CH_PCT);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) add_text(8'($urandom_range(1, 255)));
				add_text(mmt_pkg::CH_LF);
			end
			9, 10: begin
				case ($urandom_range(0, 3))
					0: add_text(mmt_pkg::CH_SPACE);
					1: add_text(mmt_pkg::CH_TAB);
					2: add_text(mmt_pkg::CH_CR);
					default: add_text(mmt_pkg::CH_LF);
				endcase
			end
			11: add_text(8'($urandom_range(0, 255)));
			12: if ($urandom_range(0, 3) == 0) add_text(mmt_pkg::CH_NUL);
			default: add_text(mmt_pkg::CH_DOT);
		endcase
		if ($urandom_range(0, 1)) add_text(mmt_pkg::CH_SPACE);
	endtask

	// sender
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_in.valid <= 1'b0;
			text_in.ch <= 8'h00;
			gap_left = 0;
		end else begin
			if (text_in.valid && text_in.ready) predict_tokens(text_in.ch);
			if (!(text_in.valid && !text_in.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					text_in.valid <= 1'b0;
				end else if (pending_text.size() != 0 && !pause_src) begin
					text_in.valid <= 1'b1;
					text_in.ch <= pending_text.pop_front();
					if ($urandom_range(0, 3) == 0)
						gap_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
							: $urandom_range(1, 2);
				end else begin
					text_in.valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		tok_byte_t got, want;
		if (!arst_n) begin
			tok_out.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (tok_out.valid && tok_out.ready) begin
				got = '{tok_out.kind, tok_out.text_byte, tok_out.start_line, tok_out.start_col,
					tok_out.tail_line, tok_out.end_col, tok_out.last};
				if (expected_bytes.size() == 0) begin
					$error("unexpected result byte %h", got.text_byte);
					n_errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d got %0d", want.kind, got.kind);
						n_errors++;
					end
					if (got.text_byte !== want.text_byte) begin
						$error("text_byte: expected %h got %h", want.text_byte, got.text_byte);
						n_errors++;
					end
					if (got.start_line !== want.start_line) begin
						$error("start_line: expected %0d got %0d", want.start_line, got.start_line);
						n_errors++;
					end
					if (got.start_col !== want.start_col) begin
						$error("start_col: expected %0d got %0d", want.start_col, got.start_col);
						n_errors++;
					end
					if (got.tail_line !== want.tail_line) begin
						$error("tail_line: expected %0d got %0d", want.tail_line, got.tail_line);
						n_errors++;
					end
					if (got.end_col !== want.end_col) begin
						$error("end_col: expected %0d got %0d", want.end_col, got.end_col);
						n_errors++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d got %0d", want.last, got.last);
						n_errors++;
					end
				end
			end
			if (hold_sink) begin
				tok_out.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				tok_out.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
				tok_out.ready <= 1'b0;
			end else begin
				tok_out.ready <= 1'b1;
			end
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if (!arst_n || (text_in.valid && text_in.ready) || (tok_out.valid && tok_out.ready)
				|| hold_sink || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_math_markup_tokenizer: errors");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_text.size() != 0 || text_in.valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		int guard;
		n_errors = 0;
		hold_sink = 1'b0;
		pause_src = 1'b0;
		stim_done = 1'b0;
		sc_mode = mmt_pkg::M_IDLE;
		sc_len = 0;
		sc_kind = mmt_pkg::KIND_END;
		sc_rem = 0;
		sc_line = 1;
		sc_col = 1;
		sc_tline = 1;
		sc_tcol = 1;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		#1 arst_n = 1'b1;

		// directed text
		add_str("\\alpha_{12.5}^x");
		add_str(" 3.x 7. 4..2 \\");
		add_text(mmt_pkg::CH_NUL);
		add_str("\\\n\\% %note\n$|");
		add_text(8'hC3); add_text(8'hA9);
		add_text(8'hE2); add_text(8'h88); add_text(8'h91);
		add_text(8'hF0); add_text(8'h9D); add_text(8'h91); add_text(8'h8E);
		add_text(8'hE2); add_text(8'h41);
		add_text(8'hF8); add_text(8'hFF); add_text(8'h80); add_text(8'h7F);
		add_str("1234567890123456789012345678901.5 ");
		add_str("abcdefghijklmnopqrstuvwxyzABCDEFGH9");
		add_str("123456789012345678901234567890.12");
		add_text(mmt_pkg::CH_PCT); add_text(mmt_pkg::CH_NUL);
		add_text(mmt_pkg::CH_NUL);
		wait_drained();

		// long receiver hold while the sender keeps offering
		hold_sink = 1'b1;
		for (int i = 0; i < 8; i++) gen_fragment();
		guard = 0;
		while (guard < 300) begin
			@(posedge clk);
			guard++;
		end
		hold_sink = 1'b0;
		wait_drained();

		// random text, one pause to full drain halfway
		for (int i = 0; i < 40; i++) gen_fragment();
		while (pending_text.size() > 70) @(posedge clk);
		pause_src = 1'b1;
		while (expected_bytes.size() != 0 || text_in.valid) @(posedge clk);
		pause_src = 1'b0;
		// a run of blanks on one line
		for (int i = 0; i < 20; i++) add_text(mmt_pkg::CH_SPACE);
		for (int i = 0; i < 4; i++) gen_fragment();
		add_text(mmt_pkg::CH_NUL);

		while (pending_text.size() != 0 || text_in.valid) @(posedge clk);
		stim_done = 1'b1;
		guard = 0;
		while (expected_bytes.size() != 0 && guard < STALL_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			$error("results still expected: %0d", expected_bytes.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("tb_math_markup_tokenizer: clean");
		else
			$display("tb_math_markup_tokenizer: errors");
		$finish;
	end

endmodule
